@@ design/slef_pkg.sv @@
`timescale 1ns / 1ps

package slef_pkg;

    localparam int unsigned LEN_W      = 16;
    localparam int unsigned MAX_FRAMES = 64;
    localparam int unsigned FOUND_W    = 7;

    localparam logic [7:0] START_MARKER_RST = 8'h68;
    localparam logic [7:0] END_MARKER_RST   = 8'h16;

    typedef enum logic [0:0] {
        REG_START_MARKER = 1'b0,
        REG_END_MARKER   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_line;
        logic       direction;
    } in_t;

    typedef struct packed {
        logic [7:0] frame_offset;
        logic [8:0] frame_size;
        logic       line_direction;
        logic       last_frame;
    } out_t;

endpackage

@@ design/start_length_end_frame_extractor.sv @@
`timescale 1ns / 1ps

// channel    | ports                                 | direction
// -----------+---------------------------------------+----------
// input      | s_valid, s_ready, s_data              | in
// result     | m_valid, m_ready, m_data              | out
// config     | cfg_valid, cfg_ready, cfg_index,      | in
//            | cfg_data                              |
//
// one byte per cycle while idle; accepted bytes go to the line store while it has room
// the scan walks the store through its single read port, searching byte by byte for a
// start marker, then reading the two length bytes and checking the length against the
// line, then reading and checking the end marker; each frame found is held until the
// next one or the finish sends it; no byte is taken during the scan, which pauses while a frame waits on m_ready
// synchronous active-low reset clears control state and restores the markers
// config writes are taken every cycle

module start_length_end_frame_extractor #(
    parameter int unsigned MAX_LINE = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  slef_pkg::in_t          s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output slef_pkg::out_t         m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  slef_pkg::cfg_index_t   cfg_index,
    input  logic [7:0]             cfg_data
);

    import slef_pkg::*;

    localparam int unsigned CW = $clog2(MAX_LINE + 1);
    localparam int unsigned AW = $clog2(MAX_LINE);
    localparam int unsigned SW = ((CW > LEN_W) ? CW : LEN_W) + 2;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SEARCH  = 8'b0000_0010,
        ST_LEN_LO  = 8'b0000_0100,
        ST_LEN_HI  = 8'b0000_1000,
        ST_LEN_CHK = 8'b0001_0000,
        ST_END_CHK = 8'b0010_0000,
        ST_FOUND   = 8'b0100_0000,
        ST_FLUSH   = 8'b1000_0000
    } state_t;

    logic [7:0]         line_mem [MAX_LINE];
    logic [7:0]         rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      issue_reg, issue_next;
    logic [CW-1:0]      cand_reg, cand_next;
    logic               chk_reg, chk_next;
    logic [CW-1:0]      s_reg, s_next;
    logic [7:0]         len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [FOUND_W-1:0] found_reg, found_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_offset_reg, pend_offset_next;
    logic [8:0]         pend_size_reg, pend_size_next;
    logic               dir_reg, dir_next;
    logic [7:0]         start_reg, end_reg;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic               out_free;
    logic               in_fire;
    logic               tail_short;
    logic               len_fail;
    logic [SW-1:0]      end_addr;
    logic [SW-1:0]      next_pos;
    logic [SW-1:0]      size_full;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign in_fire    = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign wr_en      = in_fire && (count_reg < CW'(MAX_LINE));
    assign tail_short = (SW'(issue_reg) + SW'(3)) > SW'(count_reg);
    assign size_full  = SW'(len_reg) + SW'(2);
    assign len_fail   = size_full > (SW'(count_reg) - SW'(s_reg));
    assign end_addr   = SW'(s_reg) + SW'(len_reg) + SW'(1);
    assign next_pos   = SW'(s_reg) + size_full;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[count_reg[AW-1:0]] <= s_data.data_byte;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_MARKER_RST;
            end_reg   <= END_MARKER_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_MARKER: start_reg <= cfg_data;
                REG_END_MARKER:   end_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        issue_next       = issue_reg;
        cand_next        = cand_reg;
        chk_next         = chk_reg;
        s_next           = s_reg;
        len_lo_next      = len_lo_reg;
        len_next         = len_reg;
        found_next       = found_reg;
        pend_valid_next  = pend_valid_reg;
        pend_offset_next = pend_offset_reg;
        pend_size_next   = pend_size_reg;
        dir_next         = dir_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        rd_en            = 1'b0;
        rd_addr          = issue_reg[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (wr_en) begin
                        count_next = count_reg + CW'(1);
                    end
                    if (s_data.end_of_line) begin
                        dir_next        = s_data.direction;
                        issue_next      = '0;
                        chk_next        = 1'b0;
                        found_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (chk_reg && (rd_data_reg == start_reg)) begin
                    s_next     = cand_reg;
                    rd_en      = 1'b1;
                    rd_addr    = AW'(cand_reg + CW'(1));
                    chk_next   = 1'b0;
                    state_next = ST_LEN_LO;
                end else if (tail_short) begin
                    chk_next   = 1'b0;
                    state_next = ST_FLUSH;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = issue_reg[AW-1:0];
                    cand_next  = issue_reg;
                    chk_next   = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
            end
            ST_LEN_LO: begin
                len_lo_next = rd_data_reg;
                rd_en       = 1'b1;
                rd_addr     = AW'(s_reg + CW'(2));
                state_next  = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                len_next   = {rd_data_reg, len_lo_reg};
                state_next = ST_LEN_CHK;
            end
            ST_LEN_CHK: begin
                if (len_fail) begin
                    issue_next = s_reg + CW'(1);
                    state_next = ST_SEARCH;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = end_addr[AW-1:0];
                    state_next = ST_END_CHK;
                end
            end
            ST_END_CHK: begin
                if (rd_data_reg == end_reg) begin
                    state_next = ST_FOUND;
                end else begin
                    issue_next = s_reg + CW'(1);
                    state_next = ST_SEARCH;
                end
            end
            ST_FOUND: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next                = 1'b1;
                        m_data_next.frame_offset    = pend_offset_reg;
                        m_data_next.frame_size      = pend_size_reg;
                        m_data_next.line_direction  = dir_reg;
                        m_data_next.last_frame      = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_offset_next = 8'(s_reg);
                    pend_size_next   = size_full[8:0];
                    found_next       = found_reg + FOUND_W'(1);
                    if (found_reg == FOUND_W'(MAX_FRAMES - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        issue_next = next_pos[CW-1:0];
                        chk_next   = 1'b0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next                = 1'b1;
                        m_data_next.frame_offset    = pend_offset_reg;
                        m_data_next.frame_size      = pend_size_reg;
                        m_data_next.line_direction  = dir_reg;
                        m_data_next.last_frame      = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            chk_reg        <= 1'b0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            chk_reg        <= chk_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg       <= issue_next;
        cand_reg        <= cand_next;
        s_reg           <= s_next;
        len_lo_reg      <= len_lo_next;
        len_reg         <= len_next;
        pend_offset_reg <= pend_offset_next;
        pend_size_reg   <= pend_size_next;
        dir_reg         <= dir_next;
        m_data_reg      <= m_data_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending frame left behind in idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg <= FOUND_W'(MAX_FRAMES))
        else $error("frame count beyond limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_LINE))
        else $error("line count beyond store size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) && out_free |=> (state_reg == ST_IDLE) && (count_reg == '0))
        else $error("scan did not return to idle with empty line");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import slef_pkg::*;

    localparam int unsigned LINE_DEPTH  = 256;
    localparam int unsigned SCAN_SETTLE = 1500;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_t        s_data;
    logic       m_valid;
    logic       m_ready;
    out_t       m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    logic [7:0] cfg_data;

    logic [7:0]  line_mem [LINE_DEPTH];
    int unsigned line_len;
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [7:0]  line_bytes [$];
    out_t        expected_frames [$];
    out_t        frame_due;
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned ready_hold  = 0;
    bit          idling_on   = 1'b1;

    start_length_end_frame_extractor #(
        .MAX_LINE(LINE_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 10);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: frame with none expected, actual offset %0d size %0d",
                         $time, m_data.frame_offset, m_data.frame_size);
                err_count++;
            end else begin
                frame_due = expected_frames.pop_front();
                check_field("frame_offset", 9'(frame_due.frame_offset),
                            9'(m_data.frame_offset));
                check_field("frame_size", frame_due.frame_size, m_data.frame_size);
                check_field("line_direction", 9'(frame_due.line_direction),
                            9'(m_data.line_direction));
                check_field("last_frame", 9'(frame_due.last_frame), 9'(m_data.last_frame));
            end
        end
    end

    // stores the byte and, on the last byte of a line, scans for frames
    function automatic void predict_frames(input in_t item);
        int unsigned pos;
        int unsigned s;
        int unsigned flen;
        int unsigned found;
        out_t        held;
        bit          have_held;
        if (line_len < LINE_DEPTH) begin
            line_mem[line_len] = item.data_byte;
            line_len++;
        end
        if (!item.end_of_line)
            return;
        pos       = 0;
        found     = 0;
        have_held = 1'b0;
        held      = '0;
        while (found < MAX_FRAMES && line_len >= 3 && pos <= line_len - 3) begin
            s = pos;
            while (s < line_len && line_mem[s] != start_marker)
                s++;
            if (s >= line_len || line_len - s < 3)
                break;
            flen = {line_mem[s + 2], line_mem[s + 1]};
            if (flen + 2 > line_len - s || line_mem[s + flen + 1] != end_marker) begin
                pos = s + 1;
                continue;
            end
            if (have_held)
                expected_frames.push_back(held);
            held.frame_offset   = s[7:0];
            held.frame_size     = 9'(flen + 2);
            held.line_direction = item.direction;
            held.last_frame     = 1'b0;
            have_held           = 1'b1;
            found++;
            pos = s + flen + 2;
        end
        if (have_held) begin
            held.last_frame = 1'b1;
            expected_frames.push_back(held);
        end
        line_len = 0;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic eol, input logic dir);
        in_t item;
        item.data_byte   = value;
        item.end_of_line = eol;
        item.direction   = dir;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_frames(item);
    endtask

    task automatic send_line;
        int unsigned i;
        for (i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'($urandom_range(0, 1)));
        line_bytes.delete();
    endtask

    task automatic drain_lines;
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (SCAN_SETTLE) @(posedge aclk);
    endtask

    task automatic set_markers(input logic [7:0] start_value, input logic [7:0] end_value);
        cfg_valid <= 1'b1;
        cfg_index <= REG_START_MARKER;
        cfg_data  <= start_value;
        do @(posedge aclk); while (!cfg_ready);
        start_marker = start_value;
        cfg_index <= REG_END_MARKER;
        cfg_data  <= end_value;
        do @(posedge aclk); while (!cfg_ready);
        end_marker = end_value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_lines;
        // bad end marker first, then a good frame
        line_bytes = '{8'h68, 8'h02, 8'h00, 8'h17, 8'h68, 8'h02, 8'h00, 8'h16};
        send_line();
        // frame after noise, then a candidate running past the line
        line_bytes = '{8'hFF, 8'h68, 8'h03, 8'h00, 8'hAA, 8'h16, 8'h68, 8'h09, 8'h00};
        send_line();
        // single byte line
        line_bytes = '{8'h68};
        send_line();
        drain_lines();
        set_markers(8'hFF, 8'h00);
        // lengths zero and one close inside the length field
        line_bytes = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00};
        send_line();
        drain_lines();
        set_markers(8'h00, 8'hFF);
        line_bytes = '{8'h00, 8'h02, 8'h00, 8'hFF};
        send_line();
    endtask

    task automatic test_store_full;
        int unsigned i;
        logic [7:0]  b;
        drain_lines();
        set_markers(START_MARKER_RST, END_MARKER_RST);
        // a frame ending on the last byte of the store, overflow bytes dropped
        for (i = 0; i < 252; i++) begin
            do b = 8'($urandom); while (b == start_marker);
            line_bytes.push_back(b);
        end
        line_bytes.push_back(start_marker);
        line_bytes.push_back(8'h02);
        line_bytes.push_back(8'h00);
        line_bytes.push_back(end_marker);
        for (i = 0; i < 4; i++)
            line_bytes.push_back(8'($urandom));
        send_line();
        // one frame filling the whole store
        line_bytes.push_back(start_marker);
        line_bytes.push_back(8'hFE);
        line_bytes.push_back(8'h00);
        for (i = 0; i < 252; i++)
            line_bytes.push_back(8'($urandom));
        line_bytes.push_back(end_marker);
        line_bytes.push_back(8'($urandom));
        line_bytes.push_back(8'($urandom));
        send_line();
        drain_lines();
        // zero-length frames back to back, more than the frame cap
        set_markers(8'h00, 8'h00);
        for (i = 0; i < 260; i++)
            line_bytes.push_back(8'h00);
        send_line();
    endtask

    function automatic void build_random_line;
        int unsigned segs;
        int unsigned flen;
        int unsigned i;
        segs = $urandom_range(1, 4);
        repeat (segs) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom));
                end
                3: begin
                    line_bytes.push_back(start_marker);
                    if (end_marker == 8'h00) begin
                        line_bytes.push_back(8'($urandom_range(0, 1)));
                        line_bytes.push_back(8'h00);
                    end else begin
                        line_bytes.push_back(8'($urandom));
                        line_bytes.push_back(8'($urandom_range(0, 1)));
                    end
                end
                default: begin
                    flen = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 40)
                                                        : $urandom_range(2, 6);
                    line_bytes.push_back(start_marker);
                    line_bytes.push_back(flen[7:0]);
                    line_bytes.push_back(flen[15:8]);
                    for (i = 2; i < flen; i++)
                        line_bytes.push_back(8'($urandom));
                    case ($urandom_range(0, 7))
                        0: line_bytes.push_back(end_marker ^ 8'($urandom_range(1, 255)));
                        1: ;
                        default: line_bytes.push_back(end_marker);
                    endcase
                end
            endcase
        end
    endfunction

    task automatic test_random_lines(input logic [7:0] start_value, input logic [7:0] end_value,
                                     input int unsigned item_goal);
        int unsigned sent;
        drain_lines();
        set_markers(start_value, end_value);
        sent = 0;
        while (sent < item_goal) begin
            build_random_line();
            sent += line_bytes.size();
            send_line();
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        m_ready      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_START_MARKER;
        cfg_data     <= '0;
        line_len     = 0;
        start_marker = START_MARKER_RST;
        end_marker   = END_MARKER_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_lines();
        test_store_full();
        test_random_lines(8'($urandom), 8'($urandom), 30);
        test_random_lines(8'hFF, 8'h00, 30);
        test_random_lines(8'h00, 8'hFF, 30);
        idling_on = 1'b0;
        test_random_lines(START_MARKER_RST, END_MARKER_RST, 30);
        drain_lines();

        if (err_count == 0 && expected_frames.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
